// File: src/line_sensor_centroid_tracker_top_macros.svh
// Assertion shorthands shared by the tracker modules.
// Both expect clk_i and rst_ni in scope.
`ifndef LINE_SENSOR_CENTROID_TRACKER_TOP_MACROS_SVH
`define LINE_SENSOR_CENTROID_TRACKER_TOP_MACROS_SVH

// Property checked at every clock edge outside reset.
`define LSCT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define LSCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/lsct_pkg.sv
package lsct_pkg;

  localparam int STEP_BITS = 4;
  localparam int ERR_BITS  = 8;
  localparam int ERR_GAIN  = 36;
  localparam int ERR_MAX   = 127;
  localparam int ERR_QSAT  = 128;

  typedef logic [STEP_BITS-1:0] step_t;

  typedef enum logic [1:0] {
    KIND_FLOOR = 2'd0,
    KIND_TAPE  = 2'd1,
    KIND_START = 2'd2,
    KIND_SCAN  = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    UOP_WAIT,
    UOP_DECODE,
    UOP_CLR,
    UOP_ACC,
    UOP_DIFF,
    UOP_MUL,
    UOP_DINIT,
    UOP_DIV,
    UOP_FIN,
    UOP_EMIT
  } uop_e;

  typedef enum logic [2:0] {
    JMP_NEXT,
    JMP_IN,
    JMP_CEN,
    JMP_LOOP,
    JMP_OUT
  } jmp_e;

  typedef struct packed {
    uop_e  uop;
    jmp_e  jmp;
    step_t target;
  } ucode_t;

  typedef struct packed {
    logic need_cen;
    logic cnt_last;
  } dp_stat_t;

  typedef struct packed {
    logic                       over;
    logic                       done;
    logic signed [ERR_BITS-1:0] err;
    logic                       err_valid;
    logic                       stop;
    logic                       running;
  } res_t;

  localparam step_t ST_WAIT   = 4'd0;
  localparam step_t ST_DECODE = 4'd1;
  localparam step_t ST_CLR    = 4'd2;
  localparam step_t ST_ACC    = 4'd3;
  localparam step_t ST_DIFF   = 4'd4;
  localparam step_t ST_MUL    = 4'd5;
  localparam step_t ST_DINIT  = 4'd6;
  localparam step_t ST_DIV    = 4'd7;
  localparam step_t ST_FIN    = 4'd8;
  localparam step_t ST_EMIT   = 4'd9;

  // Microprogram: one control word per step.
  function automatic ucode_t ucode_rom(input step_t s);
    case (s)
      ST_WAIT:   return '{uop: UOP_WAIT,   jmp: JMP_IN,   target: ST_WAIT};
      ST_DECODE: return '{uop: UOP_DECODE, jmp: JMP_CEN,  target: ST_EMIT};
      ST_CLR:    return '{uop: UOP_CLR,    jmp: JMP_NEXT, target: ST_WAIT};
      ST_ACC:    return '{uop: UOP_ACC,    jmp: JMP_LOOP, target: ST_WAIT};
      ST_DIFF:   return '{uop: UOP_DIFF,   jmp: JMP_NEXT, target: ST_WAIT};
      ST_MUL:    return '{uop: UOP_MUL,    jmp: JMP_NEXT, target: ST_WAIT};
      ST_DINIT:  return '{uop: UOP_DINIT,  jmp: JMP_NEXT, target: ST_WAIT};
      ST_DIV:    return '{uop: UOP_DIV,    jmp: JMP_LOOP, target: ST_WAIT};
      ST_FIN:    return '{uop: UOP_FIN,    jmp: JMP_NEXT, target: ST_WAIT};
      ST_EMIT:   return '{uop: UOP_EMIT,   jmp: JMP_OUT,  target: ST_WAIT};
      default:   return '{uop: UOP_WAIT,   jmp: JMP_IN,   target: ST_WAIT};
    endcase
  endfunction

endpackage

// File: src/lsct_useq.sv
`include "line_sensor_centroid_tracker_top_macros.svh"

module lsct_useq
  import lsct_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     out_free_i,
  input  dp_stat_t stat_i,
  output ucode_t   ucode_o
);

  step_t step_q, step_d;

  assign ucode_o = ucode_rom(step_q);

  always_comb begin
    step_d = step_q;
    case (ucode_o.jmp)
      JMP_NEXT: step_d = step_q + 1'b1;
      JMP_IN:   if (in_valid_i) step_d = step_q + 1'b1;
      JMP_CEN: begin
        // only the last lamp of an active scan runs the centroid
        step_d = stat_i.need_cen ? step_q + 1'b1 : ucode_o.target;
      end
      JMP_LOOP: if (stat_i.cnt_last) step_d = step_q + 1'b1;
      JMP_OUT:  if (out_free_i) step_d = ucode_o.target;
      default:  step_d = ST_WAIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_WAIT;
    end else begin
      step_q <= step_d;
    end
  end

  `LSCT_ASSERT(a_step_range, step_q <= ST_EMIT, "step counter left the program")
  `LSCT_ASSERT_NEXT(a_emit_return, (ucode_o.uop == UOP_EMIT) && out_free_i, step_q == ST_WAIT, "no return to wait after emit")

endmodule

// File: src/lsct_dpath.sv
`include "line_sensor_centroid_tracker_top_macros.svh"

module lsct_dpath
  import lsct_pkg::*;
#(
  parameter int NUM_LAMPS   = 7,
  parameter int SAMPLE_BITS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] kind_i,
  input  logic [2:0] lamp_i,
  input  logic [7:0] sample_i,
  input  ucode_t     ucode_i,
  output dp_stat_t   stat_o,
  output res_t       res_o
);

  localparam int SB        = SAMPLE_BITS;
  localparam int LIW       = $clog2(NUM_LAMPS);
  localparam int S0W       = SB + $clog2(NUM_LAMPS + 1);
  localparam int S1W       = SB + $clog2(NUM_LAMPS * (NUM_LAMPS + 1) / 2 + 1);
  localparam int DW        = SB + $clog2(NUM_LAMPS * (NUM_LAMPS + 1) + 1);
  localparam int NUMW      = DW + 6;
  localparam int QMAX      = (ERR_GAIN / 2) * (NUM_LAMPS - 1);
  localparam int QW        = $clog2(QMAX + 1);
  localparam int QCW       = $clog2(QW);
  localparam int CW        = DW + QW + 6;
  localparam int LAST_LAMP = NUM_LAMPS - 1;

  // latched item
  kind_e           kind_q;
  logic [2:0]      lamp_q;
  logic [SB-1:0]   smp_q;

  // tracker state
  logic [SB-1:0]   floor_q, floor_d;
  logic [SB-1:0]   thr_q, thr_d;
  logic            mission_q, mission_d;
  logic            mos_q, mos_d;
  logic            sat_q, sat_d;
  logic            scat_q, scat_d;

  // sample store
  logic [SB-1:0]   mem [NUM_LAMPS];
  logic [SB-1:0]   rdata_q;
  logic            wr_en;

  // centroid datapath
  logic [LIW-1:0]  cnt_q, cnt_d;
  logic [QCW-1:0]  dcnt_q, dcnt_d;
  logic [S0W-1:0]  s0_q, s0_d;
  logic [S1W-1:0]  s1_q, s1_d;
  logic [DW-1:0]   mag_q, mag_d;
  logic            neg_q, neg_d;
  logic            zero_q, zero_d;
  logic [NUMW-1:0] num_q, num_d;
  logic [CW-1:0]   rem_q, rem_d;
  logic [CW-1:0]   dvs_q, dvs_d;
  logic [QW-1:0]   quo_q, quo_d;
  res_t            res_q, res_d;

  logic            lamp_ok, lamp_is_first, lamp_is_last, on;
  logic [SB+1:0]   thr_sum;
  logic [S1W-1:0]  weight;
  logic [DW-1:0]   lhs, rhs;
  logic            ge;
  logic [8:0]      qsat, e9;

  assign lamp_ok       = 32'(lamp_q) < NUM_LAMPS;
  assign lamp_is_first = lamp_q == '0;
  assign lamp_is_last  = 32'(lamp_q) == LAST_LAMP;
  assign on            = smp_q >= thr_q;
  assign thr_sum       = (SB+2)'(floor_q) + (SB+2)'(smp_q) * (SB+2)'(3);
  assign weight        = S1W'(cnt_q) + S1W'(1);
  assign lhs           = DW'(s0_q) * DW'(NUM_LAMPS + 1);
  assign rhs           = DW'(s1_q) << 1;
  assign ge            = rem_q >= dvs_q;
  assign qsat          = (32'(quo_q) > ERR_QSAT) ? 9'(ERR_QSAT) : 9'(quo_q);
  assign e9            = neg_q ? (9'd0 - qsat) : ((qsat > 9'(ERR_MAX)) ? 9'(ERR_MAX) : qsat);

  assign stat_o.need_cen = (kind_q == KIND_SCAN) && mission_q && lamp_ok && lamp_is_last;
  assign stat_o.cnt_last = (ucode_i.uop == UOP_DIV) ? (dcnt_q == '0)
                                                    : (32'(cnt_q) == LAST_LAMP);
  assign res_o = res_q;

  always_comb begin
    floor_d   = floor_q;
    thr_d     = thr_q;
    mission_d = mission_q;
    mos_d     = mos_q;
    sat_d     = sat_q;
    scat_d    = scat_q;
    wr_en     = 1'b0;
    cnt_d     = cnt_q;
    dcnt_d    = dcnt_q;
    s0_d      = s0_q;
    s1_d      = s1_q;
    mag_d     = mag_q;
    neg_d     = neg_q;
    zero_d    = zero_q;
    num_d     = num_q;
    rem_d     = rem_q;
    dvs_d     = dvs_q;
    quo_d     = quo_q;
    res_d     = res_q;
    case (ucode_i.uop)
      UOP_DECODE: begin
        res_d = '0;
        case (kind_q)
          KIND_FLOOR: floor_d = smp_q;
          KIND_TAPE:  thr_d = thr_sum[SB+1:2];
          KIND_START: begin
            if (lamp_ok) begin
              sat_d = lamp_is_first ? on : (sat_q && on);
              if (lamp_is_last) begin
                mission_d = sat_d;
                mos_d     = 1'b0;
              end
            end
          end
          KIND_SCAN: begin
            if (mission_q && lamp_ok) begin
              res_d.over = on;
              if (!on) mos_d = 1'b1;
              wr_en  = 1'b1;
              scat_d = lamp_is_first ? on : (scat_q && on);
              if (lamp_is_last) begin
                res_d.done = 1'b1;
                // stop mark: whole bar on tape once off the start
                if (scat_d && mos_d) begin
                  res_d.stop = 1'b1;
                  mission_d  = 1'b0;
                end
              end
            end
          end
          default: ;
        endcase
        res_d.running = mission_d;
      end
      UOP_CLR: begin
        cnt_d = '0;
        s0_d  = '0;
        s1_d  = '0;
      end
      UOP_ACC: begin
        s0_d = s0_q + S0W'(rdata_q);
        s1_d = s1_q + S1W'(rdata_q) * weight;
        if (32'(cnt_q) != LAST_LAMP) cnt_d = cnt_q + 1'b1;
      end
      UOP_DIFF: begin
        neg_d  = rhs > lhs;
        mag_d  = (rhs > lhs) ? (rhs - lhs) : (lhs - rhs);
        zero_d = s0_q == '0;
      end
      UOP_MUL: num_d = NUMW'(mag_q) * NUMW'(ERR_GAIN);
      UOP_DINIT: begin
        rem_d  = CW'(num_q);
        // divisor 2*s0, aligned to the top quotient bit
        dvs_d  = CW'(s0_q) << QW;
        quo_d  = '0;
        dcnt_d = QCW'(QW - 1);
      end
      UOP_DIV: begin
        if (ge) rem_d = rem_q - dvs_q;
        quo_d  = {quo_q[QW-2:0], ge};
        dvs_d  = dvs_q >> 1;
        dcnt_d = dcnt_q - 1'b1;
      end
      UOP_FIN: begin
        res_d.err       = zero_q ? '0 : e9[ERR_BITS-1:0];
        res_d.err_valid = !zero_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q   <= '0;
      thr_q     <= '0;
      mission_q <= 1'b0;
      mos_q     <= 1'b0;
      sat_q     <= 1'b0;
      scat_q    <= 1'b0;
      cnt_q     <= '0;
      dcnt_q    <= '0;
    end else begin
      floor_q   <= floor_d;
      thr_q     <= thr_d;
      mission_q <= mission_d;
      mos_q     <= mos_d;
      sat_q     <= sat_d;
      scat_q    <= scat_d;
      cnt_q     <= cnt_d;
      dcnt_q    <= dcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ucode_i.uop == UOP_WAIT && in_valid_i) begin
      kind_q <= kind_e'(kind_i);
      lamp_q <= lamp_i;
      smp_q  <= SB'(sample_i);
    end
  end

  always_ff @(posedge clk_i) begin
    s0_q   <= s0_d;
    s1_q   <= s1_d;
    mag_q  <= mag_d;
    neg_q  <= neg_d;
    zero_q <= zero_d;
    num_q  <= num_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    quo_q  <= quo_d;
    res_q  <= res_d;
  end

  // read follows the next counter value so data lines up with cnt_q
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[LIW'(lamp_q)] <= smp_q;
    rdata_q <= mem[cnt_d];
  end

  `LSCT_ASSERT(a_quo_bound, (ucode_i.uop == UOP_FIN) && !zero_q |-> 32'(quo_q) <= QMAX, "quotient beyond centroid bound")
  `LSCT_ASSERT(a_fin_on_done, (ucode_i.uop == UOP_FIN) |-> res_q.done, "centroid run without a finished scan")

endmodule

// File: src/line_sensor_centroid_tracker_top.sv
// Line sensor centroid tracker.
// Input channel (in_valid_i/in_ready_o) takes one item per sample: kind, lamp
// and an 8-bit reflectance reading. Every accepted item yields exactly one
// result item on the output channel (out_valid_o/out_ready_i).
// A short microprogram in a constant table steps a plain datapath. Calibration,
// start check, inactive scans and scan lamps before the last go from decode
// straight to emit; no new item is accepted before the last one is emitted.
// The last lamp of an active scan runs the centroid: accumulation over every
// lamp through the sample store, then difference, gain multiply and a
// restoring divider that retires one quotient bit per cycle. With 7 lamps
// the quotient has 7 bits.
// Reset clears threshold, floor level, mission and scan flags; the sample
// store is not cleared and needs no clearing pass.
// The result sits in an output register; the next item is taken while it
// waits. If the receiver stalls, the sequencer holds in its emit step and
// accepts nothing further until the register is free.
`include "line_sensor_centroid_tracker_top_macros.svh"

module line_sensor_centroid_tracker_top
  import lsct_pkg::*;
#(
  parameter int NUM_LAMPS   = 7,
  parameter int SAMPLE_BITS = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 kind_i,
  input  logic [2:0]                 lamp_i,
  input  logic [7:0]                 sample_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       over_tape_o,
  output logic                       scan_done_o,
  output logic signed [ERR_BITS-1:0] error_value_o,
  output logic                       error_valid_o,
  output logic                       stop_detected_o,
  output logic                       mission_running_o
);

  ucode_t   ucode;
  dp_stat_t stat;
  res_t     res;
  res_t     out_res_q;
  logic     out_valid_q, out_valid_d;
  logic     out_free, emit;

  assign out_free   = !out_valid_q || out_ready_i;
  assign emit       = (ucode.uop == UOP_EMIT) && out_free;
  assign in_ready_o = ucode.uop == UOP_WAIT;

  lsct_useq u_useq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_free_i (out_free),
    .stat_i     (stat),
    .ucode_o    (ucode)
  );

  lsct_dpath #(
    .NUM_LAMPS   (NUM_LAMPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .kind_i     (kind_i),
    .lamp_i     (lamp_i),
    .sample_i   (sample_i),
    .ucode_i    (ucode),
    .stat_o     (stat),
    .res_o      (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) out_res_q <= res;
  end

  assign out_valid_o       = out_valid_q;
  assign over_tape_o       = out_res_q.over;
  assign scan_done_o       = out_res_q.done;
  assign error_value_o     = out_res_q.err;
  assign error_valid_o     = out_res_q.err_valid;
  assign stop_detected_o   = out_res_q.stop;
  assign mission_running_o = out_res_q.running;

  `LSCT_ASSERT(a_valid_needs_done, out_valid_q && out_res_q.err_valid |-> out_res_q.done, "error valid outside a finished scan")
  `LSCT_ASSERT(a_stop_ends_mission, out_valid_q && out_res_q.stop |-> !out_res_q.running, "stop reported with mission still running")

endmodule

// File: tb/sv/line_sensor_centroid_checker.sv
`timescale 1ns / 100ps

module line_sensor_centroid_checker
  import lsct_pkg::*;
#(
  parameter int NUM_LAMPS = 7
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  logic [1:0]                 kind_i,
  input  logic [2:0]                 lamp_i,
  input  logic [7:0]                 sample_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  logic                       over_tape_i,
  input  logic                       scan_done_i,
  input  logic signed [ERR_BITS-1:0] error_value_i,
  input  logic                       error_valid_i,
  input  logic                       stop_detected_i,
  input  logic                       mission_running_i,
  output int                         fail_count_o,
  output int                         pending_o,
  output int                         stops_o
);

  logic [7:0] floor_lvl;
  logic [7:0] thr;
  logic       armed;
  logic       left_start;
  logic       start_ok;
  logic       scan_ok;
  logic [7:0] lamp_store [NUM_LAMPS];

  res_t due_q [$];
  int   fails = 0;
  int   stops = 0;

  task automatic report(input string what, input int got, input int want);
    $display("%0t ns  mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    fails++;
  endtask

  // Advance the tracker state by one item and return the result it yields.
  function automatic res_t track_item(input kind_e k, input logic [2:0] l,
                                      input logic [7:0] s);
    res_t r;
    logic on;
    int   i;
    int   s0;
    int   s1;
    int   num;
    int   q;
    r  = '0;
    on = (s >= thr);
    case (k)
      KIND_FLOOR: floor_lvl = s;
      KIND_TAPE:  thr = 8'((int'(floor_lvl) + 3 * int'(s)) >> 2);
      KIND_START: begin
        if (l < NUM_LAMPS) begin
          start_ok = (l == 0) ? on : (start_ok && on);
          if (l == NUM_LAMPS - 1) begin
            armed      = start_ok;
            left_start = 1'b0;
          end
        end
      end
      KIND_SCAN: begin
        if (armed && l < NUM_LAMPS) begin
          r.over = on;
          if (!on) left_start = 1'b1;
          lamp_store[l] = s;
          scan_ok = (l == 0) ? on : (scan_ok && on);
          if (l == NUM_LAMPS - 1) begin
            s0 = 0;
            s1 = 0;
            for (i = 0; i < NUM_LAMPS; i++) begin
              s0 += int'(lamp_store[i]);
              s1 += (i + 1) * int'(lamp_store[i]);
            end
            r.done = 1'b1;
            // Zero sum leaves the error at zero and flagged invalid.
            if (s0 != 0) begin
              num = ERR_GAIN * ((NUM_LAMPS + 1) * s0 - 2 * s1);
              q   = ((num < 0) ? -num : num) / (2 * s0);
              if (q > ERR_QSAT) q = ERR_QSAT;
              if (num < 0) q = -q;
              if (q > ERR_MAX) q = ERR_MAX;
              r.err       = q[ERR_BITS-1:0];
              r.err_valid = 1'b1;
            end
            if (scan_ok && left_start) begin
              r.stop = 1'b1;
              armed  = 1'b0;
            end
          end
        end
      end
      default: ;
    endcase
    r.running = armed;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      floor_lvl  = '0;
      thr        = '0;
      armed      = 1'b0;
      left_start = 1'b0;
      start_ok   = 1'b0;
      scan_ok    = 1'b0;
      due_q.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
      stops_o      <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (due_q.size() == 0) begin
          report("result with nothing pending", 1, 0);
        end else begin
          want = due_q.pop_front();
          if (over_tape_i !== want.over)
            report("over_tape", int'(over_tape_i), int'(want.over));
          if (scan_done_i !== want.done)
            report("scan_done", int'(scan_done_i), int'(want.done));
          if (error_value_i !== want.err)
            report("error_value", int'(error_value_i), int'(want.err));
          if (error_valid_i !== want.err_valid)
            report("error_valid", int'(error_valid_i), int'(want.err_valid));
          if (stop_detected_i !== want.stop)
            report("stop_detected", int'(stop_detected_i), int'(want.stop));
          if (mission_running_i !== want.running)
            report("mission_running", int'(mission_running_i), int'(want.running));
          if (want.stop) stops++;
        end
      end
      if (in_valid_i && in_ready_i) begin
        due_q.push_back(track_item(kind_e'(kind_i), lamp_i, sample_i));
      end
      pending_o    <= due_q.size();
      fail_count_o <= fails;
      stops_o      <= stops;
    end
  end

endmodule

// File: tb/sv/tb_line_sensor_centroid_tracker_top.sv
`timescale 1ns / 100ps

module tb_line_sensor_centroid_tracker_top;
  import lsct_pkg::*;

  localparam int NUM_LAMPS   = 7;
  localparam int LAST_LAMP   = NUM_LAMPS - 1;
  localparam int ITEM_TARGET = 550;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  kind_e      kind      = KIND_FLOOR;
  logic [2:0] lamp      = '0;
  logic [7:0] sample    = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;

  logic                       over_tape;
  logic                       scan_done;
  logic signed [ERR_BITS-1:0] error_value;
  logic                       error_valid;
  logic                       stop_detected;
  logic                       mission_running;

  int fail_count;
  int pending;
  int stops;

  // Stretches with no idling on either side.
  bit calm = 1'b0;

  // Threshold as the stimulus last set it, to steer samples to tape or floor.
  logic [7:0] stim_floor = '0;
  logic [7:0] stim_thr   = '0;

  int sent    = 0;
  int useful  = 0;
  int n_cal   = 0;
  int n_start = 0;
  int n_scan  = 0;

  always #1 clk = ~clk;

  line_sensor_centroid_tracker_top uut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .kind_i            (kind),
    .lamp_i            (lamp),
    .sample_i          (sample),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .over_tape_o       (over_tape),
    .scan_done_o       (scan_done),
    .error_value_o     (error_value),
    .error_valid_o     (error_valid),
    .stop_detected_o   (stop_detected),
    .mission_running_o (mission_running)
  );

  line_sensor_centroid_checker #(
    .NUM_LAMPS (NUM_LAMPS)
  ) u_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_i        (in_ready),
    .kind_i            (kind),
    .lamp_i            (lamp),
    .sample_i          (sample),
    .out_valid_i       (out_valid),
    .out_ready_i       (out_ready),
    .over_tape_i       (over_tape),
    .scan_done_i       (scan_done),
    .error_value_i     (error_value),
    .error_valid_i     (error_valid),
    .stop_detected_i   (stop_detected),
    .mission_running_i (mission_running),
    .fail_count_o      (fail_count),
    .pending_o         (pending),
    .stops_o           (stops)
  );

  task automatic send_item(input kind_e k, input logic [2:0] l, input logic [7:0] s);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    lamp     <= l;
    sample   <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (k == KIND_FLOOR) stim_floor = s;
    else if (k == KIND_TAPE) stim_thr = 8'((int'(stim_floor) + 3 * int'(s)) >> 2);
    sent++;
    if (!(l >= NUM_LAMPS && (k == KIND_START || k == KIND_SCAN))) useful++;
  endtask

  function automatic logic [7:0] tape_val();
    return 8'($urandom_range(255, stim_thr));
  endfunction

  function automatic logic [7:0] floor_val();
    return (stim_thr == 0) ? 8'd0 : 8'($urandom_range(int'(stim_thr) - 1, 0));
  endfunction

  // Drop valid and hold off until every result is back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // mode: 0 typical levels, 1 any levels, 2 tape level only
  task automatic calibrate(input int mode);
    if (mode == 0) send_item(KIND_FLOOR, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 100)));
    if (mode == 1) send_item(KIND_FLOOR, 3'($urandom_range(0, 7)), 8'($urandom));
    if (mode == 0) send_item(KIND_TAPE, 3'($urandom_range(0, 7)), 8'($urandom_range(150, 255)));
    else send_item(KIND_TAPE, 3'($urandom_range(0, 7)), 8'($urandom));
    n_cal++;
  endtask

  // mode: 0 all tape, 1 one lamp on floor, 2 random readings, 3 cut short
  task automatic start_check(input int mode);
    int i;
    int bad;
    int last;
    logic [7:0] s;
    bad  = $urandom_range(0, LAST_LAMP);
    last = (mode == 3) ? $urandom_range(0, LAST_LAMP - 1) : LAST_LAMP;
    for (i = 0; i <= last; i++) begin
      case (mode)
        1:       s = (i == bad) ? floor_val() : tape_val();
        2:       s = 8'($urandom);
        default: s = tape_val();
      endcase
      send_item(KIND_START, 3'(i), s);
    end
    n_start++;
  endtask

  // mode: 0 tape/floor mix, 1 all tape, 2 one lamp lit, 3 all zero,
  //       4 raw random readings, 5 mix cut short
  task automatic scan_pass(input int mode);
    int i;
    int hot;
    int last;
    logic [7:0] s;
    hot  = $urandom_range(0, LAST_LAMP);
    last = (mode == 5) ? $urandom_range(0, LAST_LAMP - 1) : LAST_LAMP;
    for (i = 0; i <= last; i++) begin
      case (mode)
        1:       s = tape_val();
        2:       s = (i == hot) ? 8'($urandom_range(1, 255)) : 8'd0;
        3:       s = 8'd0;
        4:       s = 8'($urandom);
        default: s = $urandom_range(0, 1) ? tape_val() : floor_val();
      endcase
      send_item(KIND_SCAN, 3'(i), s);
    end
    if (mode != 5) n_scan++;
  endtask

  initial begin
    int gap;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      gap = calm ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    int pick;
    int sel;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Scan before any start check, then a start item past the last lamp.
    send_item(KIND_SCAN, 3'(LAST_LAMP), 8'hFF);
    send_item(KIND_START, 3'd7, 8'h00);
    send_item(KIND_FLOOR, 3'd7, 8'h00);
    send_item(KIND_TAPE, 3'd0, 8'hFF);
    start_check(0);
    // All-zero scan: zero sum, every lamp on floor; fills the whole store.
    scan_pass(3);
    send_item(KIND_SCAN, 3'd7, 8'hFF);
    // Every lamp on tape after leaving the start: stop mark.
    scan_pass(1);
    n_cal++;
    wait_drained();

    while (useful < ITEM_TARGET) begin
      if ($urandom_range(0, 15) == 0) calm = !calm;
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        calibrate($urandom_range(0, 2));
      end else if (pick < 32) begin
        sel = $urandom_range(0, 19);
        start_check((sel < 10) ? 0 : (sel < 14) ? 1 : (sel < 17) ? 2 : 3);
      end else if (pick < 88) begin
        scan_pass($urandom_range(0, 5));
      end else begin
        send_item(kind_e'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), 8'($urandom));
      end
      // Hold off now and then until every result is back.
      if ($urandom_range(0, 59) == 0) wait_drained();
    end

    wait_drained();
    repeat (30) @(posedge clk);
    $display("covered %0d items: %0d calibrations, %0d start checks, %0d full scans",
             sent, n_cal, n_start, n_scan);
    $display("%0d stop marks seen, %0d mismatches, %0d results outstanding",
             stops, fail_count, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #500000;
    $display("timeout with %0d results outstanding", pending);
    $display("FAIL");
    $finish;
  end

endmodule
